// ===== src/dsit_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsit_pkg: shared definitions of the deduplicating key table
// Operation and status codes, fixed result field widths and the control
// group that the sequencer hands to the ring of entry cells.
// ----------------------------------------------------------------------------
package dsit_pkg;

  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 9;
  localparam int GLYPH_W  = 8;
  localparam int FILL_W   = 10;
  localparam int OUT_W    = SLOT_W + GLYPH_W + FILL_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_CLEARED   = 2'd3;

  // Ring control: shift rotates every cell one place toward the head,
  // wr replaces the entry leaving the head with the new key.
  typedef struct packed {
    logic shift;
    logic wr;
  } dsit_ring_ctl_t;

endpackage

// ===== src/dsit_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsit_cell: one table entry in the rotating ring
// Holds one packed entry and takes its neighbor's entry on every shift.
// ----------------------------------------------------------------------------
module dsit_cell #(
  parameter int W = 33
) (
  input  logic         clk,
  input  logic         shift,
  input  logic [W-1:0] din,
  output logic [W-1:0] q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= din;
    end
  end

endmodule

// ===== src/dsit_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsit_ctrl: sequencer of the key table
// Takes one beat at a time. Inserts into a non-full table rotate the ring once
// around comparing head and key and appends on a miss. Results are registered.
// ----------------------------------------------------------------------------
module dsit_ctrl
  import dsit_pkg::*;
#(
  parameter int CAPACITY   = 512,
  parameter int COORD_BITS = 12,
  parameter int ENTRY_W    = 2 * COORD_BITS + 1 + GLYPH_W
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_func,
  input  logic [ENTRY_W-1:0]     in_entry,
  input  logic [ENTRY_W-1:0]     head_entry,
  output dsit_ring_ctl_t         ring,
  output logic [ENTRY_W-1:0]     new_entry,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [STATUS_W-1:0]    out_status,
  output logic [SLOT_W-1:0]      out_slot,
  output logic [GLYPH_W-1:0]     out_glyph,
  output logic [FILL_W-1:0]      out_fill
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int KEY_W = 2 * COORD_BITS + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]          state;
  logic [IDX_W-1:0]    step;
  logic [CNT_W-1:0]    count;
  logic [ENTRY_W-1:0]  item;
  logic                hit;
  logic [IDX_W-1:0]    hit_idx;
  logic [GLYPH_W-1:0]  hit_glyph;
  logic [STATUS_W-1:0] res_status;
  logic [SLOT_W-1:0]   res_slot;
  logic [GLYPH_W-1:0]  res_glyph;
  logic [FILL_W-1:0]   res_fill;

  logic [CNT_W-1:0] step_ext;
  logic             in_range;
  logic             key_eq;
  logic             last_step;
  logic             accept;
  logic             emit_go;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == S_IDLE);
  assign step_ext  = CNT_W'(step);
  assign in_range  = (step_ext < count);
  assign key_eq    = (head_entry[KEY_W-1:0] == item[KEY_W-1:0]);
  assign last_step = (step == IDX_W'(CAPACITY - 1));
  assign new_entry = item;
  assign emit_go   = (state == S_EMIT) && (!out_valid || out_ready);

  always_comb begin
    ring.shift = (state == S_SCAN);
    // Entry number count sits at the head exactly when step reaches it.
    ring.wr    = (state == S_SCAN) && !hit && (step_ext == count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      hit       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            item <= in_entry;
            step <= '0;
            hit  <= 1'b0;
            if (in_func == FUNC_CLEAR) begin
              count      <= '0;
              res_status <= ST_CLEARED;
              res_slot   <= '0;
              res_glyph  <= '0;
              res_fill   <= '0;
              state      <= S_EMIT;
            end else if (count == CNT_W'(CAPACITY)) begin
              res_status <= ST_FULL;
              res_slot   <= '0;
              res_glyph  <= '0;
              res_fill   <= FILL_W'(count);
              state      <= S_EMIT;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          step <= step + 1'b1;
          if (!hit && in_range && key_eq) begin
            hit       <= 1'b1;
            hit_idx   <= step;
            hit_glyph <= head_entry[ENTRY_W-1 -: GLYPH_W];
          end
          // The ring must go all the way around so every entry returns home.
          if (last_step) begin
            state <= S_EMIT;
            if (hit) begin
              res_status <= ST_DUPLICATE;
              res_slot   <= SLOT_W'(hit_idx);
              res_glyph  <= hit_glyph;
              res_fill   <= FILL_W'(count);
            end else begin
              res_status <= ST_INSERTED;
              res_slot   <= SLOT_W'(count);
              res_glyph  <= item[ENTRY_W-1 -: GLYPH_W];
              res_fill   <= FILL_W'(count + 1'b1);
              count      <= count + 1'b1;
            end
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_status <= res_status;
      out_slot   <= res_slot;
      out_glyph  <= res_glyph;
      out_fill   <= res_fill;
    end
  end

endmodule

// ===== src/dedup_set_insert_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dedup_set_insert_table_unit: deduplicating table of triangle keys
// Top level: ring of entry cells, sequencer and stream ports.
// ----------------------------------------------------------------------------
// The table keeps up to CAPACITY unique keys (column, row, up bit) with a
// glyph byte each, in a ring of cells that rotates one place per cycle past a
// single comparator at the head. An insert beat is accepted, then takes
// CAPACITY rotation steps that bring every entry past the head once and back
// to its place, then loads the result register once any earlier result has
// been taken. A clear beat or an insert into a full table skips the rotation.
// The next beat is accepted while a result still waits on the master side.
// Slot and fill count are reported modulo their field widths when CAPACITY
// exceeds them.
module dedup_set_insert_table_unit
  import dsit_pkg::*;
#(
  parameter int CAPACITY   = 512,
  parameter int COORD_BITS = 12
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // s_tdata, lowest bit up: key_col, key_row, key_up, glyph_in, zero fill
  input  logic [((2 * COORD_BITS + 1 + GLYPH_W + 7) / 8) * 8 - 1:0] s_tdata,
  // s_tuser: func
  input  logic s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // m_tdata, lowest bit up: slot, slot_glyph, fill_count, zero fill
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // m_tuser: status
  output logic [STATUS_W-1:0] m_tuser
);

  localparam int ENTRY_W = 2 * COORD_BITS + 1 + GLYPH_W;

  logic [ENTRY_W-1:0] cell_q [CAPACITY];
  logic [ENTRY_W-1:0] tail_in;
  logic [ENTRY_W-1:0] new_entry;
  dsit_ring_ctl_t     ring;

  logic [SLOT_W-1:0]  out_slot;
  logic [GLYPH_W-1:0] out_glyph;
  logic [FILL_W-1:0]  out_fill;

  dsit_ctrl #(
    .CAPACITY   (CAPACITY),
    .COORD_BITS (COORD_BITS),
    .ENTRY_W    (ENTRY_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_func    (s_tuser),
    .in_entry   (s_tdata[ENTRY_W-1:0]),
    .head_entry (cell_q[0]),
    .ring       (ring),
    .new_entry  (new_entry),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (m_tuser),
    .out_slot   (out_slot),
    .out_glyph  (out_glyph),
    .out_fill   (out_fill)
  );

  // The head entry wraps to the tail unless it is the free slot being filled.
  assign tail_in = ring.wr ? new_entry : cell_q[0];

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [ENTRY_W-1:0] din;
    if (k == CAPACITY - 1) begin : g_tail
      assign din = tail_in;
    end else begin : g_body
      assign din = cell_q[k + 1];
    end
    dsit_cell #(
      .W (ENTRY_W)
    ) u_cell (
      .clk   (clk),
      .shift (ring.shift),
      .din   (din),
      .q     (cell_q[k])
    );
  end

  assign m_tdata = OUT_TDATA_W'({out_fill, out_glyph, out_slot});

  a_wr_needs_shift: assert property (@(posedge clk) disable iff (rst)
    ring.wr |-> ring.shift)
    else $error("ring write without rotation");

  a_no_accept_in_scan: assert property (@(posedge clk) disable iff (rst)
    ring.shift |-> !s_tready)
    else $error("input ready while the ring rotates");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second beat accepted before the first finished");

endmodule

// ===== tb/dedup_table_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dedup_table_monitor: result predictor and comparator for the key table
// Watches both stream channels of the deduplicating key table. Every
// accepted input beat is run through a behavioral copy of the table, and
// every accepted result beat is checked field by field against the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
module dedup_table_monitor
  import dsit_pkg::*;
#(
  parameter int CAPACITY   = 512,
  parameter int COORD_BITS = 12,
  parameter int IN_TDATA_W = ((2 * COORD_BITS + 1 + GLYPH_W + 7) / 8) * 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  input  logic                    s_tready,
  input  logic [IN_TDATA_W-1:0]   s_tdata,
  input  logic                    s_tuser,
  input  logic                    m_tvalid,
  input  logic                    m_tready,
  input  logic [OUT_TDATA_W-1:0]  m_tdata,
  input  logic [STATUS_W-1:0]     m_tuser,
  output int                      fail_count,
  output int                      outstanding
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [GLYPH_W-1:0]  glyph;
    logic [FILL_W-1:0]   fill;
  } table_outcome_t;

  // Shadow copy of the table contents.
  logic [COORD_BITS-1:0] col_mem   [CAPACITY];
  logic [COORD_BITS-1:0] row_mem   [CAPACITY];
  logic                  up_mem    [CAPACITY];
  logic [GLYPH_W-1:0]    glyph_mem [CAPACITY];
  int                    fill_level;
  int                    err_total;

  table_outcome_t expected_outcomes [$];

  function automatic table_outcome_t apply_table_op(
    input logic                  func,
    input logic [COORD_BITS-1:0] col,
    input logic [COORD_BITS-1:0] row,
    input logic                  up,
    input logic [GLYPH_W-1:0]    glyph
  );
    table_outcome_t res;
    int idx;
    res = '0;
    if (func == FUNC_CLEAR) begin
      fill_level = 0;
      res.status = ST_CLEARED;
      return res;
    end
    // A full table refuses the key before any search is made.
    if (fill_level >= CAPACITY) begin
      res.status = ST_FULL;
      res.fill   = FILL_W'(fill_level);
      return res;
    end
    for (idx = 0; idx < fill_level; idx++) begin
      if (col_mem[idx] == col && row_mem[idx] == row && up_mem[idx] == up) begin
        res.status = ST_DUPLICATE;
        res.slot   = SLOT_W'(idx);
        res.glyph  = glyph_mem[idx];
        res.fill   = FILL_W'(fill_level);
        return res;
      end
    end
    col_mem[fill_level]   = col;
    row_mem[fill_level]   = row;
    up_mem[fill_level]    = up;
    glyph_mem[fill_level] = glyph;
    res.status = ST_INSERTED;
    res.slot   = SLOT_W'(fill_level);
    res.glyph  = glyph;
    fill_level = fill_level + 1;
    res.fill   = FILL_W'(fill_level);
    return res;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      err_total++;
    end
  endtask

  always @(posedge clk) begin : watch_beats
    table_outcome_t want;
    if (rst) begin
      fill_level = 0;
      expected_outcomes.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_outcomes.size() == 0) begin
          $error("result beat with no outstanding item: status %0d, data %0h",
                 m_tuser, m_tdata);
          err_total++;
        end else begin
          want = expected_outcomes.pop_front();
          check_field("status", 32'(want.status), 32'(m_tuser));
          check_field("slot", 32'(want.slot), 32'(m_tdata[SLOT_W-1:0]));
          check_field("slot_glyph", 32'(want.glyph), 32'(m_tdata[SLOT_W +: GLYPH_W]));
          check_field("fill_count", 32'(want.fill),
                      32'(m_tdata[SLOT_W + GLYPH_W +: FILL_W]));
        end
      end
      if (s_tvalid && s_tready) begin
        expected_outcomes.push_back(apply_table_op(
          s_tuser,
          s_tdata[COORD_BITS-1:0],
          s_tdata[COORD_BITS +: COORD_BITS],
          s_tdata[2 * COORD_BITS],
          s_tdata[2 * COORD_BITS + 1 +: GLYPH_W]));
      end
    end
    outstanding <= expected_outcomes.size();
    fail_count  <= err_total;
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the deduplicating key table
// Sends a directed set of inserts and clears, then random runs over small
// key pools and one run that fills the table to capacity, with bursty input,
// a stalling result side and one long result hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import dsit_pkg::*;

  localparam int CAPACITY      = 512;
  localparam int COORD_BITS    = 12;
  localparam int KEY_W         = 2 * COORD_BITS + 1 + GLYPH_W;
  localparam int IN_TDATA_W    = ((KEY_W + 7) / 8) * 8;
  localparam int POOL_MAX      = 12;
  localparam int TOTAL_ITEMS   = 600;
  localparam int HOLD_CYCLES   = 3000;
  localparam int SETTLE_CYCLES = 600;
  // The longest quiet stretch of a correct run is the result hold-off plus
  // one full search and the longest input gap.
  localparam int WATCHDOG_LIMIT = 20000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // s_tdata, lowest bit up: key_col, key_row, key_up, glyph_in, zero fill
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  // s_tuser: func
  logic                   s_tuser = FUNC_INSERT;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // m_tdata, lowest bit up: slot, slot_glyph, fill_count, zero fill
  logic [OUT_TDATA_W-1:0] m_tdata;
  // m_tuser: status
  logic [STATUS_W-1:0]    m_tuser;

  int fail_count;
  int outstanding;
  int sent_count = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  logic [COORD_BITS-1:0] fill_col [CAPACITY];
  logic [COORD_BITS-1:0] fill_row [CAPACITY];
  logic                  fill_up  [CAPACITY];

  dedup_set_insert_table_unit #(
    .CAPACITY  (CAPACITY),
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  dedup_table_monitor #(
    .CAPACITY  (CAPACITY),
    .COORD_BITS(COORD_BITS),
    .IN_TDATA_W(IN_TDATA_W)
  ) monitor (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Offer one beat and wait for it to be taken; the burst counter decides
  // whether valid stays high for the next beat or a gap follows.
  task automatic offer_beat(
    input logic                  func,
    input logic [COORD_BITS-1:0] col,
    input logic [COORD_BITS-1:0] row,
    input logic                  up,
    input logic [GLYPH_W-1:0]    glyph
  );
    int gap;
    s_tuser  <= func;
    s_tdata  <= {{(IN_TDATA_W - KEY_W){1'b0}}, glyph, up, row, col};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sent_count++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(21, 600) : $urandom_range(1, 20);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 5);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // A clear beat carries random values in the fields that it ignores.
  task automatic offer_clear();
    offer_beat(FUNC_CLEAR, COORD_BITS'($urandom), COORD_BITS'($urandom),
               1'($urandom), GLYPH_W'($urandom));
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Mix of full-range values, values around zero and the two extremes.
  function automatic logic [COORD_BITS-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0: rand_coord = $urandom_range(0, 1) ? {1'b0, {(COORD_BITS - 1){1'b1}}}
                                           : {1'b1, {(COORD_BITS - 1){1'b0}}};
      1: rand_coord = COORD_BITS'($urandom_range(0, 8)) - COORD_BITS'(4);
      default: rand_coord = COORD_BITS'($urandom);
    endcase
  endfunction

  // A short run over a small pool of keys, so that duplicates are common.
  task automatic run_pool_sequence();
    logic [COORD_BITS-1:0] pool_col [POOL_MAX];
    logic [COORD_BITS-1:0] pool_row [POOL_MAX];
    logic                  pool_up  [POOL_MAX];
    int pool_n, n, k, pick, roll;
    pool_n = $urandom_range(1, POOL_MAX);
    for (k = 0; k < pool_n; k++) begin
      pool_col[k] = rand_coord();
      pool_row[k] = rand_coord();
      pool_up[k]  = 1'($urandom_range(0, 1));
    end
    if ($urandom_range(0, 1) == 0)
      offer_clear();
    n = $urandom_range(4, 20);
    for (k = 0; k < n; k++) begin
      roll = $urandom_range(0, 19);
      pick = $urandom_range(0, pool_n - 1);
      if (roll == 0)
        offer_clear();
      else if (roll < 3)
        offer_beat(FUNC_INSERT, rand_coord(), rand_coord(), 1'($urandom),
                   GLYPH_W'($urandom));
      else
        offer_beat(FUNC_INSERT, pool_col[pick], pool_row[pick], pool_up[pick],
                   GLYPH_W'($urandom));
    end
  endtask

  // Fill the table to capacity with unique keys, with repeats mixed in, then
  // try inserts against the full table on both sides of a full drain.
  task automatic fill_to_capacity();
    logic [COORD_BITS-1:0] row_off;
    int i, k, pick;
    row_off = COORD_BITS'($urandom);
    offer_clear();
    for (i = 0; i < CAPACITY; i++) begin
      fill_col[i] = COORD_BITS'($urandom);
      fill_row[i] = COORD_BITS'(i) ^ row_off;
      fill_up[i]  = 1'($urandom_range(0, 1));
      offer_beat(FUNC_INSERT, fill_col[i], fill_row[i], fill_up[i], GLYPH_W'($urandom));
      if ($urandom_range(0, 9) == 0) begin
        pick = $urandom_range(0, i);
        offer_beat(FUNC_INSERT, fill_col[pick], fill_row[pick], fill_up[pick],
                   GLYPH_W'($urandom));
      end
    end
    for (k = 0; k < 5; k++) begin
      if (k == 3) drain_results();
      pick = $urandom_range(0, CAPACITY - 1);
      if (k % 2 == 0)
        offer_beat(FUNC_INSERT, fill_col[pick], fill_row[pick], fill_up[pick],
                   GLYPH_W'($urandom));
      else
        offer_beat(FUNC_INSERT, rand_coord(), rand_coord(), 1'($urandom),
                   GLYPH_W'($urandom));
    end
    offer_clear();
  endtask

  initial begin : stimulus
    logic [COORD_BITS-1:0] c_min, c_max, c_neg1, c_zero, rc, rr;
    logic ru;
    int seq, fill_at;
    bit fill_done;
    c_min  = {1'b1, {(COORD_BITS - 1){1'b0}}};
    c_max  = {1'b0, {(COORD_BITS - 1){1'b1}}};
    c_neg1 = '1;
    c_zero = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    offer_beat(FUNC_INSERT, c_min, c_min, 1'b0, 8'h00);
    offer_beat(FUNC_INSERT, c_max, c_max, 1'b1, 8'hff);
    offer_beat(FUNC_INSERT, c_min, c_min, 1'b0, 8'h5a);
    offer_beat(FUNC_INSERT, c_max, c_max, 1'b1, 8'h00);
    // Keys that differ from an existing one in a single component.
    offer_beat(FUNC_INSERT, c_min, c_min, 1'b1, 8'ha5);
    offer_beat(FUNC_INSERT, c_min + 1'b1, c_min, 1'b0, 8'h01);
    offer_beat(FUNC_INSERT, c_min, c_min + 1'b1, 1'b0, 8'h02);
    offer_beat(FUNC_INSERT, c_zero, c_zero, 1'b0, 8'h80);
    offer_beat(FUNC_INSERT, c_neg1, c_neg1, 1'b1, 8'h7f);
    offer_beat(FUNC_INSERT, c_neg1, c_zero, 1'b1, 8'h33);
    offer_beat(FUNC_INSERT, c_zero, c_neg1, 1'b1, 8'hcc);
    offer_beat(FUNC_INSERT, c_zero, c_zero, 1'b0, 8'h11);
    offer_clear();
    // Stale entries behind a clear must not be found again.
    offer_beat(FUNC_INSERT, c_max, c_max, 1'b1, 8'h3c);
    offer_beat(FUNC_INSERT, c_min, c_min, 1'b0, 8'hc3);
    offer_clear();
    offer_clear();
    rc = COORD_BITS'($urandom);
    rr = COORD_BITS'($urandom);
    ru = 1'($urandom);
    offer_beat(FUNC_INSERT, rc, rr, ru, GLYPH_W'($urandom));
    offer_beat(FUNC_INSERT, rc, rr, ru, GLYPH_W'($urandom));

    seq = 0;
    fill_at = $urandom_range(0, 4);
    fill_done = 1'b0;
    while (!fill_done || sent_count < TOTAL_ITEMS) begin
      if (seq == fill_at) begin
        fill_to_capacity();
        fill_done = 1'b1;
      end else begin
        run_pool_sequence();
      end
      if ($urandom_range(0, 2) == 0) drain_results();
      seq++;
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

  // Result side: segments of always ready, random stalls and a sparse
  // periodic pattern, with one long hold-off that backs up the input side.
  initial begin : result_sink
    int cyc, hold_at, seg_left, mode;
    cyc = 0;
    seg_left = 0;
    mode = 0;
    hold_at = $urandom_range(15000, 60000);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == hold_at) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (seg_left == 0) begin
        mode = $urandom_range(0, 2);
        seg_left = $urandom_range(10, 400);
      end
      seg_left--;
      case (mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 1) == 1);
        default: m_tready <= (cyc % 5 == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
